/* rtl/core/chtab_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash id table package
// Shared constants and operation codes for the hash table core.
// ----------------------------------------------------------------------------
package chtab_pkg;

  localparam int DefMaxBuckets  = 128;
  localparam int DefPoolEntries = 256;
  localparam logic [7:0] ResetBuckets = 8'd101;

  // Operation codes carried on the mode port.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_UNIQUE = 2'd3;

  // Status codes returned with each result.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

endpackage

/* rtl/core/chtab_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module chtab_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/chained_hash_id_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash id table
// Maps signed 32-bit ids to handles through bucket chains in an entry pool.
// ----------------------------------------------------------------------------
//  Channel | Ports                                 | Handshake
//  input   | in_mode, in_key, in_handle            | start && !busy
//  result  | out_status, out_handle_out, out_id_out| out_valid, one cycle
//  config  | cfg_data                              | cfg_valid && cfg_ready
//
// After reset a clearing pass nulls the bucket heads and links the free list;
// busy is high meanwhile.
// The bucket index is the key modulo the bucket count, by restoring division.
// An insert reads the head and links a free entry; other modes walk the chain,
// and unique-id walks all buckets in use on meeting an id not below the key.
// Results cannot be stalled; a result is shown for one cycle with out_valid.
// ----------------------------------------------------------------------------
module chained_hash_id_table_top #(
  parameter int MAX_BUCKETS  = chtab_pkg::DefMaxBuckets,
  parameter int POOL_ENTRIES = chtab_pkg::DefPoolEntries
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_key,
  input  logic [31:0] in_handle,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_handle_out,
  output logic signed [31:0] out_id_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  import chtab_pkg::*;

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int PW = $clog2(POOL_ENTRIES + 1);
  localparam int EW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(MAX_BUCKETS + 1);
  localparam logic [PW-1:0] NullLink = PW'(POOL_ENTRIES);

  // State codes.
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_HWAIT = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_RWAIT = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_INS   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_SCAN  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [7:0]    bcount_r;
  logic [1:0]    mode_r;
  logic [31:0]   key_r, handle_r;
  logic [32:0]   rem_r;
  logic [31:0]   quo_r;
  logic [5:0]    cnt_r;
  logic [BW-1:0] bucket_r;
  logic [PW-1:0] p_r, prev_r, free_r;
  logic [$clog2(MAX_BUCKETS+POOL_ENTRIES+1)-1:0] clr_r;
  logic [8:0]    guard_r;
  logic signed [31:0] best_r;
  logic          scan_r;
  logic [CW-1:0] sb_r;
  logic [1:0]    st_r;
  logic [31:0]   hout_r, idout_r;
  logic          ov_r;

  // Bucket count in use: zero is one, saturated to MAX_BUCKETS.
  logic [CW-1:0] nb;
  always_comb begin
    if (bcount_r == 8'd0) begin
      nb = CW'(1);
    end else if (32'(bcount_r) > 32'(MAX_BUCKETS)) begin
      nb = CW'(MAX_BUCKETS);
    end else begin
      nb = CW'(bcount_r);
    end
  end

  // Memories: bucket heads, entry key/handle/next, free links.
  logic          hd_we;  logic [BW-1:0] hd_wa, hd_ra; logic [PW-1:0] hd_wd, hd_rd;
  logic          en_we;  logic [EW-1:0] en_wa, en_ra;
  logic [31:0]   ek_wd, ek_rd, eh_wd, eh_rd;
  logic          nx_we;  logic [EW-1:0] nx_wa;  logic [PW-1:0] nx_wd, nx_rd;
  logic          fl_we;  logic [EW-1:0] fl_wa, fl_ra; logic [PW-1:0] fl_wd, fl_rd;

  chtab_ram #(.Width(PW), .Depth(MAX_BUCKETS)) u_head (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  chtab_ram #(.Width(32), .Depth(POOL_ENTRIES)) u_key (
    .clk, .we(en_we), .waddr(en_wa), .wdata(ek_wd), .raddr(en_ra), .rdata(ek_rd));
  chtab_ram #(.Width(32), .Depth(POOL_ENTRIES)) u_hdl (
    .clk, .we(en_we), .waddr(en_wa), .wdata(eh_wd), .raddr(en_ra), .rdata(eh_rd));
  chtab_ram #(.Width(PW), .Depth(POOL_ENTRIES)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(en_ra), .rdata(nx_rd));
  chtab_ram #(.Width(PW), .Depth(POOL_ENTRIES)) u_free (
    .clk, .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));

  logic p_is_entry;
  logic key_match, key_ge, skip;
  logic [32:0] trial;
  assign p_is_entry = (p_r < NullLink) && (guard_r < 9'(POOL_ENTRIES > 256 ? 256 : POOL_ENTRIES))
                      || ((POOL_ENTRIES > 256) && (p_r < NullLink));
  assign key_match  = (ek_rd == key_r);
  assign key_ge     = ($signed(ek_rd) >= $signed(key_r));
  assign skip       = (mode_r == MODE_LOOKUP) && (key_r == 32'hFFFF_FFFF);
  assign trial      = {rem_r[31:0], quo_r[31]} - {25'd0, 8'(nb)};

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_handle_out = hout_r;
  assign out_id_out = idout_r;

  // Memory port control.
  always_comb begin
    hd_we = 1'b0; hd_wa = bucket_r; hd_wd = p_r; hd_ra = bucket_r;
    en_we = 1'b0; en_wa = p_r[EW-1:0]; ek_wd = key_r; eh_wd = handle_r;
    en_ra = p_r[EW-1:0];
    nx_we = 1'b0; nx_wa = p_r[EW-1:0]; nx_wd = hd_rd;
    fl_we = 1'b0; fl_wa = p_r[EW-1:0]; fl_wd = free_r; fl_ra = free_r[EW-1:0];
    if (state_r == S_CLEAR) begin
      if (32'(clr_r) < 32'(MAX_BUCKETS)) begin
        hd_we = 1'b1; hd_wa = BW'(clr_r); hd_wd = NullLink;
      end else begin
        fl_we = 1'b1;
        fl_wa = EW'(32'(clr_r) - 32'(MAX_BUCKETS));
        fl_wd = PW'(32'(clr_r) - 32'(MAX_BUCKETS) + 1);
      end
    end
    if (state_r == S_INS) begin
      en_we = 1'b1; nx_we = 1'b1; hd_we = 1'b1;
    end
    if (state_r == S_CHK && p_is_entry && !skip && key_match &&
        mode_r == MODE_REMOVE) begin
      if (prev_r < NullLink) begin
        nx_we = 1'b1; nx_wa = prev_r[EW-1:0]; nx_wd = nx_rd;
      end else begin
        hd_we = 1'b1; hd_wd = nx_rd;
      end
      fl_we = 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      bcount_r <= ResetBuckets;
      free_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      ov_r <= (state_r == S_DONE);
      if (cfg_valid && cfg_ready) begin
        bcount_r <= cfg_data;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == MAX_BUCKETS + POOL_ENTRIES - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            mode_r <= in_mode; key_r <= in_key; handle_r <= in_handle;
            rem_r <= '0; quo_r <= in_key; cnt_r <= '0;
            st_r <= ST_OK; hout_r <= '0; idout_r <= '0;
            guard_r <= '0; prev_r <= NullLink; scan_r <= 1'b0;
            best_r <= '0;
            state_r <= S_DIV;
          end
        end
        // One restoring division step per cycle.
        S_DIV: begin
          if (!trial[32]) rem_r <= trial;
          else rem_r <= {rem_r[31:0], quo_r[31]};
          quo_r <= {quo_r[30:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'd31) state_r <= S_HEAD;
        end
        S_HEAD: begin
          bucket_r <= BW'(rem_r);
          if (mode_r == MODE_INSERT && free_r == NullLink) begin
            st_r <= ST_FULL; state_r <= S_DONE;
          end else begin
            state_r <= S_HWAIT;
          end
        end
        S_HWAIT: begin
          // Head read is valid next cycle; fetch free link too.
          state_r <= S_RD;
          guard_r <= '0;
        end
        S_RD: begin
          if (mode_r == MODE_INSERT) begin
            p_r <= free_r;
            state_r <= S_INS;
          end else begin
            p_r <= hd_rd;
            state_r <= S_RWAIT;
          end
        end
        S_INS: begin
          free_r <= fl_rd;
          state_r <= S_DONE;
        end
        S_RWAIT: state_r <= S_CHK;
        S_CHK: begin
          if (!p_is_entry || skip) begin
            if (scan_r) begin
              state_r <= S_SCAN;
            end else begin
              if (mode_r == MODE_UNIQUE) idout_r <= key_r;
              else st_r <= ST_NOTFOUND;
              state_r <= S_DONE;
            end
          end else if (scan_r) begin
            if ($signed(ek_rd) > best_r) best_r <= $signed(ek_rd);
            p_r <= nx_rd; guard_r <= guard_r + 1'b1; state_r <= S_RWAIT;
          end else if (mode_r == MODE_UNIQUE && key_ge) begin
            scan_r <= 1'b1; sb_r <= '0; state_r <= S_SCAN;
          end else if (mode_r != MODE_UNIQUE && key_match) begin
            if (mode_r == MODE_LOOKUP) hout_r <= eh_rd;
            else free_r <= p_r;
            state_r <= S_DONE;
          end else begin
            prev_r <= p_r; p_r <= nx_rd; guard_r <= guard_r + 1'b1;
            state_r <= S_RWAIT;
          end
        end
        // Walk every bucket in use for the highest id.
        S_SCAN: begin
          if (sb_r >= nb) begin
            idout_r <= (best_r == 32'sh7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(best_r + 1);
            state_r <= S_DONE;
          end else begin
            bucket_r <= BW'(sb_r); sb_r <= sb_r + 1'b1;
            state_r <= S_HWAIT;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/chtab_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table port checker
// Port-level properties of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module chtab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [31:0] out_handle_out,
  input logic [31:0] out_id_out,
  input logic        cfg_ready
);

  import chtab_pkg::*;

  // An accepted transaction makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after accept");

  // A result is a single-cycle strobe.
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held");

  // A result ends the busy period.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy with result");

  // Status only shows a defined code.
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NOTFOUND ||
                   out_status == ST_FULL)) else $error("bad status");

  // Config is ready exactly when idle.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready == !busy) else $error("config ready mismatch");

endmodule

bind chained_hash_id_table_top chtab_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_status,
  .out_handle_out, .out_id_out, .cfg_ready);
